// ===== hdl/trpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer reload PWM generator package
// Shared constants, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package trpg_pkg;

	localparam int DEF_TIMER_CLOCK_HZ = 921600;
	localparam int DEF_COUNTER_WIDTH  = 16;

	localparam int FREQ_W     = 16;
	localparam int DUTY_W     = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int TDATA_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_HZ      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERCENT = 2'd2;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd100;
	localparam logic [FREQ_W-1:0] MIN_FREQ   = 16'd15;
	localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
	localparam logic [DUTY_W-1:0] PERCENT    = 7'd100;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV1  = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_FIN   = 5'b10000
	} ctrl_state_t;

	typedef struct packed {
		logic wr_freq;
		logic wr_duty;
		logic snap;
		logic start;
		logic step;
		logic mul;
		logic scale;
		logic fin;
		logic load_ctr;
		logic stop;
		logic running;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage

// ===== hdl/trpg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer reload PWM generator controller
// Decodes register writes, keeps the run state and sequences the reload
// computation through one divider pass, a multiply and a reciprocal scaling.
// ----------------------------------------------------------------------------
module trpg_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                              cfg_run_bit,
	input  trpg_pkg::dp_status_t              status,
	output trpg_pkg::ctrl_cmd_t               cmd,
	output logic                              busy
);

	trpg_pkg::ctrl_state_t state_q, state_nx;
	logic running_q, load_pend_q, req_q;
	logic wr_run, run1, run0, start;

	assign wr_run = cfg_we && (cfg_index == trpg_pkg::REG_RUN_ENABLE);
	assign run1   = wr_run && cfg_run_bit;
	assign run0   = wr_run && !cfg_run_bit;
	assign start  = (state_q == trpg_pkg::ST_IDLE) && req_q && !run0;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			trpg_pkg::ST_IDLE: begin
				if (start) state_nx = trpg_pkg::ST_DIV1;
			end
			trpg_pkg::ST_DIV1: begin
				if (status.div_last) state_nx = trpg_pkg::ST_MUL;
			end
			trpg_pkg::ST_MUL: begin
				state_nx = trpg_pkg::ST_SCALE;
			end
			trpg_pkg::ST_SCALE: begin
				state_nx = trpg_pkg::ST_FIN;
			end
			trpg_pkg::ST_FIN: begin
				state_nx = trpg_pkg::ST_IDLE;
			end
			default: begin
				state_nx = trpg_pkg::ST_IDLE;
			end
		endcase
		if (run0) state_nx = trpg_pkg::ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trpg_pkg::ST_IDLE;
			running_q   <= 1'b0;
			load_pend_q <= 1'b0;
			req_q       <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (run0) begin
				running_q   <= 1'b0;
				load_pend_q <= 1'b0;
				req_q       <= 1'b0;
			end else begin
				if (run1) running_q <= 1'b1;
				if (run1 && !running_q) begin
					load_pend_q <= 1'b1;
				end else if (state_q == trpg_pkg::ST_FIN) begin
					load_pend_q <= 1'b0;
				end
				if (run1) begin
					req_q <= 1'b1;
				end else if (start) begin
					req_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.wr_freq  = cfg_we && (cfg_index == trpg_pkg::REG_FREQ_HZ);
		cmd.wr_duty  = cfg_we && (cfg_index == trpg_pkg::REG_DUTY_PERCENT);
		cmd.snap     = run1;
		cmd.start    = start;
		cmd.step     = (state_q == trpg_pkg::ST_DIV1);
		cmd.mul      = (state_q == trpg_pkg::ST_MUL) && !run0;
		cmd.scale    = (state_q == trpg_pkg::ST_SCALE) && !run0;
		cmd.fin      = (state_q == trpg_pkg::ST_FIN) && !run0;
		cmd.load_ctr = load_pend_q;
		cmd.stop     = run0;
		cmd.running  = running_q;
	end

	assign busy = (state_q != trpg_pkg::ST_IDLE) || req_q;

	a_pend_running: assert property (@(posedge clk) disable iff (!arst_n)
		load_pend_q |-> running_q)
		else $error("counter load pending while stopped");

	a_busy_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != trpg_pkg::ST_IDLE) |-> running_q)
		else $error("reload computation active while stopped");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == trpg_pkg::ST_FIN) |=> (state_q == trpg_pkg::ST_IDLE))
		else $error("controller did not return to idle after finishing");

endmodule

// ===== hdl/trpg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer reload PWM generator datapath
// Holds the registers, a one-bit-per-cycle restoring divider for the period,
// the duty multiplier, a reciprocal scaling by one hundred, the reload
// values, the phase counter and the output beat.
// ----------------------------------------------------------------------------
module trpg_dp #(
	parameter int TIMER_CLOCK_HZ = trpg_pkg::DEF_TIMER_CLOCK_HZ,
	parameter int COUNTER_WIDTH  = trpg_pkg::DEF_COUNTER_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  trpg_pkg::ctrl_cmd_t                cmd,
	input  logic [trpg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               accept,
	input  logic                               tick,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic                               pwm_level,
	output logic                               phase_overflow,
	output logic                               out_free,
	output trpg_pkg::dp_status_t               status
);

	localparam int CW       = COUNTER_WIDTH;
	localparam int CLK_BITS = $clog2(TIMER_CLOCK_HZ + 1);
	localparam int NW       = (CLK_BITS > CW + 8) ? CLK_BITS : CW + 8;
	localparam int CNT_W    = $clog2(NW);
	localparam int FW       = trpg_pkg::FREQ_W;
	localparam int DW       = trpg_pkg::DUTY_W;
	localparam int PW       = CW + 8;
	localparam int RSH      = PW + 7;
	localparam int RW       = PW + 2;
	localparam logic [CW:0] SPAN = {1'b1, {CW{1'b0}}};
	localparam logic [63:0] RECIP_L = ((64'd1 << RSH) + 64'(trpg_pkg::PERCENT) - 64'd1)
		/ 64'(trpg_pkg::PERCENT);
	localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

	logic [FW-1:0]    freq_q, snap_freq_q, freq_clamp;
	logic [DW-1:0]    duty_q, snap_duty_q, act_duty_q, duty_clamp;
	logic [CW:0]      period_q, period_sat, hi_q, lo, neg_hi, neg_lo;
	logic [FW-1:0]    rem_q, dvs_q, rem_nx;
	logic [NW-1:0]    quo_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [FW:0]      shifted;
	logic [FW+1:0]    diff;
	logic             ge;
	logic [PW-1:0]    prod;
	logic [PW+RW-1:0] scaled;
	logic [CW-1:0]    high_reload_q, low_reload_q, ctr_q, ctr_inc;
	logic             level_q, tick_run, wrap, level_nx;
	logic             m_tvalid_q, m_level_q, m_ovf_q;

	assign freq_clamp = (snap_freq_q < trpg_pkg::MIN_FREQ) ? trpg_pkg::MIN_FREQ : snap_freq_q;
	assign duty_clamp = (snap_duty_q > trpg_pkg::PERCENT) ? trpg_pkg::PERCENT : snap_duty_q;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[FW+1];
	assign rem_nx  = ge ? diff[FW-1:0] : shifted[FW-1:0];

	assign period_sat = (quo_q > NW'(SPAN)) ? SPAN : quo_q[CW:0];
	assign prod       = PW'(period_sat) * PW'(act_duty_q);

	// The high count is the registered product divided by one hundred, done as a
	// multiply by a rounded-up reciprocal that is exact over the product range.
	assign scaled = (PW + RW)'(quo_q[PW-1:0]) * (PW + RW)'(RECIP);

	assign lo     = period_q - hi_q;
	assign neg_hi = '0 - hi_q;
	assign neg_lo = '0 - lo;

	assign status.div_last = (div_cnt_q == CNT_W'(NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= trpg_pkg::FREQ_RESET;
			duty_q <= trpg_pkg::DUTY_RESET;
		end else begin
			if (cmd.wr_freq) freq_q <= cfg_data[FW-1:0];
			if (cmd.wr_duty) duty_q <= cfg_data[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			snap_freq_q <= freq_q;
			snap_duty_q <= duty_q;
		end
		if (cmd.start) begin
			quo_q      <= NW'(TIMER_CLOCK_HZ);
			rem_q      <= '0;
			dvs_q      <= freq_clamp;
			act_duty_q <= duty_clamp;
			div_cnt_q  <= '0;
		end else if (cmd.mul) begin
			period_q <= period_sat;
			quo_q    <= NW'(prod);
		end else if (cmd.step) begin
			quo_q     <= {quo_q[NW-2:0], ge};
			rem_q     <= rem_nx;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.scale) hi_q <= scaled[RSH +: CW + 1];
	end

	assign tick_run = accept && cmd.running && tick;
	assign ctr_inc  = ctr_q + 1'b1;
	assign wrap     = tick_run && (ctr_inc == '0);
	assign level_nx = wrap ? !level_q : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_reload_q <= '0;
			low_reload_q  <= '0;
			ctr_q         <= '0;
			level_q       <= 1'b0;
		end else if (cmd.stop) begin
			high_reload_q <= '0;
			low_reload_q  <= '0;
			level_q       <= 1'b0;
		end else if (cmd.fin) begin
			high_reload_q <= neg_hi[CW-1:0];
			low_reload_q  <= neg_lo[CW-1:0];
			if (cmd.load_ctr) begin
				ctr_q   <= neg_hi[CW-1:0];
				level_q <= 1'b1;
			end
		end else if (tick_run) begin
			if (wrap) begin
				ctr_q   <= level_q ? low_reload_q : high_reload_q;
				level_q <= level_nx;
			end else begin
				ctr_q <= ctr_inc;
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_level_q <= cmd.running && level_nx;
			m_ovf_q   <= wrap;
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign pwm_level      = m_level_q;
	assign phase_overflow = m_ovf_q;

	a_low_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.running |-> !level_q)
		else $error("output level high while stopped");

endmodule

// ===== hdl/timer_reload_pwm_generator_unit.sv =====
`timescale 1ns / 1ps
// Latency: a result beat appears in the cycle after its input beat is taken.
// Throughput: one tick beat per cycle while no reload computation runs and the output has room.
// Writing 1 to run_enable starts a computation through the bit-serial period
// divider, a multiply and a reciprocal scaling; no beat is taken then.
// Reset clears the run state, the counter and the reloads and loads the
// register defaults; the output channel comes up empty.
// ----------------------------------------------------------------------------
// Timer reload PWM generator
// Stream wrapper joining the controller and the datapath, with the beat
// handshake on both sides and a plain register write port.
// ----------------------------------------------------------------------------
module timer_reload_pwm_generator_unit #(
	parameter int TIMER_CLOCK_HZ = trpg_pkg::DEF_TIMER_CLOCK_HZ,
	parameter int COUNTER_WIDTH  = trpg_pkg::DEF_COUNTER_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [trpg_pkg::TDATA_W-1:0]      s_tdata,   // tick
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [trpg_pkg::TDATA_W-1:0]      m_tdata,   // pwm_level, phase_overflow
	input  logic                              cfg_we,
	input  logic [trpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	trpg_pkg::ctrl_cmd_t  cmd;
	trpg_pkg::dp_status_t status;
	logic busy, out_free, accept, pwm_level, phase_overflow;

	assign s_tready = !busy && out_free;
	assign accept   = s_tvalid && s_tready;

	trpg_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_run_bit (cfg_data[0]),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy)
	);

	trpg_dp #(
		.TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
		.COUNTER_WIDTH  (COUNTER_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.tick           (s_tdata[0]),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.pwm_level      (pwm_level),
		.phase_overflow (phase_overflow),
		.out_free       (out_free),
		.status         (status)
	);

	assign m_tdata = {{(trpg_pkg::TDATA_W - 2){1'b0}}, phase_overflow, pwm_level};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer reload PWM generator testbench
// Drives tick beats and register writes into the generator and checks every
// output beat against a cycle-free model of the counter, the reloads and the
// output level, or against the values of a short directed table that covers
// the stopped state, clamping, overflow and restart. Random phases with
// random settings and random stalls on both streams follow.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CFG_IDX_W  = trpg_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = trpg_pkg::CFG_DATA_W;
	localparam int TDATA_W    = trpg_pkg::TDATA_W;
	localparam int FREQ_W     = trpg_pkg::FREQ_W;
	localparam int DUTY_W     = trpg_pkg::DUTY_W;
	localparam int CW         = trpg_pkg::DEF_COUNTER_WIDTH;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned TIMER_HZ     = trpg_pkg::DEF_TIMER_CLOCK_HZ;
	localparam int unsigned SPAN         = 1 << CW;
	localparam int          RANDOM_BEATS = 850;
	localparam int          PLAN_LEN     = 25;
	localparam int          MAX_PRINTS   = 50;

	typedef enum logic {OP_WRITE, OP_BEAT} op_t;

	typedef struct packed {
		op_t                   op;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  tick;
		logic [7:0]            rep;
		logic                  typed;
		logic                  level;
		logic                  ovf;
	} plan_row_t;

	typedef struct packed {
		logic level;
		logic ovf;
	} pwm_out_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Model state of the generator.
	logic                        run_on;
	logic [FREQ_W-1:0]           freq_reg;
	logic [DUTY_W-1:0]           duty_reg;
	logic [CW-1:0]               phase_ctr;
	logic [CW-1:0]               high_rl;
	logic [CW-1:0]               low_rl;
	logic                        level_q;

	pwm_out_t pwm_expected[$];
	int       err_count    = 0;
	int       results_seen = 0;
	int       rx_hold      = 0;
	int       rx_cycle     = 0;
	bit       rx_calm      = 1'b1;

	timer_reload_pwm_generator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		err_count++;
		if (err_count <= MAX_PRINTS) begin
			$display("%0t: result %0d: %s expected %0d got %0d",
				$time, results_seen, what, want, got);
		end
	endtask

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		int unsigned f, d, period, hi, lo;
		case (idx)
			trpg_pkg::REG_RUN_ENABLE: begin
				if (data[0]) begin
					f = (freq_reg < trpg_pkg::MIN_FREQ) ? trpg_pkg::MIN_FREQ : freq_reg;
					d = (duty_reg > trpg_pkg::PERCENT) ? trpg_pkg::PERCENT : duty_reg;
					period = TIMER_HZ / f;
					if (period > SPAN) period = SPAN;
					hi = period * d / trpg_pkg::PERCENT;
					lo = period - hi;
					high_rl = CW'(SPAN - hi);
					low_rl  = CW'(SPAN - lo);
					if (!run_on) begin
						phase_ctr = high_rl;
						level_q   = 1'b1;
					end
					run_on = 1'b1;
				end else begin
					run_on  = 1'b0;
					level_q = 1'b0;
					high_rl = '0;
					low_rl  = '0;
				end
			end
			trpg_pkg::REG_FREQ_HZ:      freq_reg = data[FREQ_W-1:0];
			trpg_pkg::REG_DUTY_PERCENT: duty_reg = data[DUTY_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic pwm_out_t advance_pwm(input logic tick);
		pwm_out_t r;
		r.ovf = 1'b0;
		if (run_on && tick) begin
			phase_ctr = phase_ctr + 1'b1;
			if (phase_ctr == '0) begin
				r.ovf = 1'b1;
				if (level_q) begin
					level_q   = 1'b0;
					phase_ctr = low_rl;
				end else begin
					level_q   = 1'b1;
					phase_ctr = high_rl;
				end
			end
		end
		r.level = run_on & level_q;
		return r;
	endfunction

	function automatic int pick_gap(input int mode);
		int r;
		if (mode == 0) return 0;
		r = $urandom_range(0, 15);
		if (r < 9) return 0;
		if (r < 14) return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 7))
			0: return FREQ_W'($urandom_range(0, 16));
			1: return FREQ_W'($urandom);
			2: return {FREQ_W{1'b1}};
			default: return FREQ_W'($urandom_range(9000, 65535));
		endcase
	endfunction

	function automatic logic [DUTY_W-1:0] pick_duty();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return trpg_pkg::PERCENT;
			2, 3: return DUTY_W'($urandom_range(101, 127));
			default: return DUTY_W'($urandom_range(1, 99));
		endcase
	endfunction

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pwm_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_reg_write(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic tick, input logic typed, input pwm_out_t want);
		pwm_out_t pred;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-1){1'b0}}, tick};
		do @(posedge clk); while (!s_tready);
		pred = advance_pwm(tick);
		pwm_expected.push_back(typed ? want : pred);
	endtask

	task automatic sender_pause(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : rx_side
		pwm_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pwm_expected.size() == 0) begin
					report_mismatch("result with nothing pending", 0, m_tdata);
				end else begin
					want = pwm_expected.pop_front();
					if (m_tdata[0] !== want.level)
						report_mismatch("pwm_level", want.level, m_tdata[0]);
					if (m_tdata[1] !== want.ovf)
						report_mismatch("phase_overflow", want.ovf, m_tdata[1]);
				end
				results_seen++;
			end
			rx_cycle++;
			if (rx_cycle % 128 == 0) rx_calm = ($urandom_range(0, 2) == 0);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 5) == 0) begin
					rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
						: $urandom_range(1, 3);
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan [0:PLAN_LEN-1];
		pwm_out_t  want;
		int        random_sent;
		int        phase;
		int        n_items;
		int        sender_mode;
		int        wait_cycles;

		plan = '{
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b0, 8'd1,  1'b1, 1'b0, 1'b0},
			'{OP_WRITE, REG_UNUSED,                 16'hFFFF, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_FREQ_HZ,      16'hFFFF, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_DUTY_PERCENT, 16'h007F, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'h0001, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b0, 8'd1,  1'b1, 1'b1, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd13, 1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b1, 1'b0, 1'b1},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'hFFFE, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_FREQ_HZ,      16'h0000, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_DUTY_PERCENT, 16'h0000, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'h0001, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_DUTY_PERCENT, 16'h0032, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'h8001, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_FREQ_HZ,      16'h000E, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_DUTY_PERCENT, 16'h0064, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_WRITE, trpg_pkg::REG_RUN_ENABLE,   16'h0001, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
			'{OP_BEAT,  trpg_pkg::REG_RUN_ENABLE,   16'h0000, 1'b1, 8'd1,  1'b1, 1'b1, 1'b0}
		};

		run_on    = 1'b0;
		freq_reg  = trpg_pkg::FREQ_RESET;
		duty_reg  = trpg_pkg::DUTY_RESET;
		phase_ctr = '0;
		high_rl   = '0;
		low_rl    = '0;
		level_q   = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == OP_WRITE) begin
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				want.level = plan[i].level;
				want.ovf   = plan[i].ovf;
				repeat (plan[i].rep) begin
					send_tick(plan[i].tick, plan[i].typed, want);
					sender_pause(pick_gap(1));
				end
			end
		end

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_BEATS) begin
			sender_mode = $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0)
				write_reg(trpg_pkg::REG_RUN_ENABLE, CFG_DATA_W'($urandom) & 16'hFFFE);
			if ($urandom_range(0, 4) != 0)
				write_reg(trpg_pkg::REG_FREQ_HZ, pick_freq());
			if ($urandom_range(0, 4) != 0)
				write_reg(trpg_pkg::REG_DUTY_PERCENT, {9'($urandom), pick_duty()});
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			write_reg(trpg_pkg::REG_RUN_ENABLE,
				{15'($urandom), 1'($urandom_range(0, 7) != 0)});
			n_items = $urandom_range(10, 60);
			for (int k = 0; k < n_items; k++) begin
				send_tick(1'($urandom_range(0, 4) != 0), 1'b0, '0);
				random_sent++;
				if (k == n_items / 2 && (phase == 1 || $urandom_range(0, 5) == 0))
					drain_results();
				else
					sender_pause(pick_gap(sender_mode));
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		wait_cycles = 0;
		while (pwm_expected.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pwm_expected.size() != 0)
			report_mismatch("results never delivered", 0, pwm_expected.size());
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
